// File: sv/first_fit_page_allocator_macros.svh
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ffpa_pkg.sv
// shared constants for the first-fit page allocator
package ffpa_pkg;

    // page map depth default
    localparam int MAX_PAGES_DEF = 1024;

    // page size as a power of two
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

    // field widths
    localparam int ADDR_W  = 48;
    localparam int REQ_W   = 32;
    localparam int PAGES_W = 11;
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 4;

    // width of the page count needed by the largest request
    localparam int NEED_W = REQ_W - PAGE_SHIFT + 1;

    // register select, taken from paddr bit 3
    localparam logic CFG_SEL_BASE  = 1'b0;
    localparam logic CFG_SEL_PAGES = 1'b1;

    localparam logic [PAGES_W-1:0] PAGES_RESET = PAGES_W'(1024);

endpackage

// File: sv/ffpa_page_map.sv
// page-used bit map: one write port, one registered read port
module ffpa_page_map #(
    parameter int DEPTH = ffpa_pkg::MAX_PAGES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/first_fit_page_allocator.sv
// first-fit contiguous page allocator, top level
//
//  channel  dir  handshake        words
//  s_       in   s_valid/s_ready  s_request_bytes
//  m_       out  m_valid/m_ready  m_block_address, m_out_of_memory
//  apb      in   psel/penable     region_base @0x0, pages_available @0x8
//
// a request makes one page map read per cycle while scanning up to the effective
// page count, then one write per page marked; zero-page and oversize requests
// skip the scan and go straight to the done state
// after reset a clearing pass writes every map entry with s_ready low; apb
// writes are taken during it
// a finished word waits in the output register; the next request is taken
// once the previous one has been handed to that register
module first_fit_page_allocator #(
    parameter int MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ffpa_pkg::REQ_W-1:0]  s_request_bytes,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ffpa_pkg::ADDR_W-1:0] m_block_address,
    output logic                        m_out_of_memory,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffpa_pkg::APB_AW-1:0] paddr,
    input  logic [ffpa_pkg::APB_DW-1:0] pwdata,
    output logic [ffpa_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

`include "first_fit_page_allocator_macros.svh"

    localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int ADDR_W = ffpa_pkg::ADDR_W;
    localparam int NEED_W = ffpa_pkg::NEED_W;
    localparam int SHIFT  = ffpa_pkg::PAGE_SHIFT;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // configuration
    logic [ADDR_W-1:0]            region_base_reg;
    logic [ffpa_pkg::PAGES_W-1:0] pages_avail_reg;
    logic                         cfg_we;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  chk_reg, chk_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  need_reg, need_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_oom_reg, res_oom_next;

    // output word
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic              m_oom_reg, m_oom_next;

    // page map ports
    logic              wr_en, wr_data, rd_en, rd_data;
    logic [IDX_W-1:0]  wr_addr, rd_addr;

    logic [NEED_W-1:0] need_w;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  run_inc;
    logic [CNT_W-1:0]  first_w;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
            pages_avail_reg <= ffpa_pkg::PAGES_RESET;
        end else if (cfg_we) begin
            if (paddr[3] == ffpa_pkg::CFG_SEL_PAGES) begin
                pages_avail_reg <= pwdata[ffpa_pkg::PAGES_W-1:0];
            end else begin
                region_base_reg <= pwdata[ADDR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == ffpa_pkg::CFG_SEL_PAGES) begin
            prdata = ffpa_pkg::APB_DW'(pages_avail_reg);
        end else begin
            prdata = ffpa_pkg::APB_DW'(region_base_reg);
        end
    end

    // ---------------- request decode ----------------
    // ceil(bytes / page size)
    assign need_w = NEED_W'(s_request_bytes >> SHIFT)
                  + NEED_W'(|s_request_bytes[SHIFT-1:0]);

    always_comb begin
        if (32'(pages_avail_reg) > 32'(MAX_PAGES)) begin
            eff_count = CNT_W'(MAX_PAGES);
        end else begin
            eff_count = CNT_W'(pages_avail_reg);
        end
    end

    assign run_inc = run_reg + CNT_W'(1);
    assign first_w = chk_reg + CNT_W'(1) - need_reg;

    // ---------------- page map ----------------
    ffpa_page_map #(
        .DEPTH (MAX_PAGES),
        .IDX_W (IDX_W)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        chk_next      = chk_reg;
        pend_next     = pend_reg;
        run_next      = run_reg;
        need_next     = need_reg;
        count_next    = count_reg;
        first_next    = first_reg;
        res_addr_next = res_addr_reg;
        res_oom_next  = res_oom_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_oom_next    = m_oom_reg;
        wr_en         = 1'b0;
        wr_data       = 1'b0;
        wr_addr       = addr_reg[IDX_W-1:0];
        rd_en         = 1'b0;
        rd_addr       = addr_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (addr_reg == CNT_W'(MAX_PAGES - 1)) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    need_next  = CNT_W'(need_w);
                    count_next = eff_count;
                    addr_next  = '0;
                    run_next   = '0;
                    pend_next  = 1'b0;
                    priority if (need_w == '0) begin
                        res_addr_next = region_base_reg;
                        res_oom_next  = 1'b0;
                        state_next    = ST_DONE;
                    end else if (32'(need_w) > 32'(eff_count)) begin
                        res_addr_next = '0;
                        res_oom_next  = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read one page ahead of the check
                if (addr_reg < count_reg) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    chk_next  = addr_reg;
                    addr_next = addr_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (rd_data) begin
                        run_next = '0;
                    end else if (run_inc == need_reg) begin
                        first_next = first_w[IDX_W-1:0];
                        addr_next  = first_w;
                        run_next   = need_reg;
                        state_next = ST_MARK;
                    end else begin
                        run_next = run_inc;
                    end
                end else if (addr_reg == count_reg) begin
                    res_addr_next = '0;
                    res_oom_next  = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_MARK: begin
                wr_en     = 1'b1;
                wr_data   = 1'b1;
                addr_next = addr_reg + CNT_W'(1);
                run_next  = run_reg - CNT_W'(1);
                if (run_reg == CNT_W'(1)) begin
                    res_addr_next = region_base_reg + (ADDR_W'(first_reg) << SHIFT);
                    res_oom_next  = 1'b0;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_oom_next   = res_oom_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_reg      <= chk_next;
        run_reg      <= run_next;
        need_reg     <= need_next;
        count_reg    <= count_next;
        first_reg    <= first_next;
        res_addr_reg <= res_addr_next;
        res_oom_reg  <= res_oom_next;
        m_addr_reg   <= m_addr_next;
        m_oom_reg    <= m_oom_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_block_address = m_addr_reg;
    assign m_out_of_memory = m_oom_reg;

    // ---------------- assertions ----------------
    `FFPA_ASSERT_NOW(a_oom_zero_addr, m_valid_reg && m_oom_reg, m_addr_reg == '0, "failed word carries a nonzero address")
    `FFPA_ASSERT_NOW(a_run_below_need, state_reg == ST_SCAN, run_reg < need_reg, "free run reached the need without leaving the scan")
    `FFPA_ASSERT_NOW(a_mark_in_range, state_reg == ST_MARK, addr_reg < count_reg && run_reg != '0, "mark write outside the page count")
    `FFPA_ASSERT_NEXT(a_zero_req_fast, s_valid && s_ready && need_w == '0, state_reg == ST_DONE && !res_oom_reg, "zero-page request did not finish at once")

endmodule
